/* design/ale_pkg.sv */
// shared constants for the associated legendre evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package ale_pkg;

  localparam int MAX_BAND  = 7;
  localparam int FRAC_BITS = 30;

  localparam int BAND_W = 3;
  localparam int X_W    = 32;
  localparam int VAL_W  = 64;
  localparam int PROD_W = 2 * VAL_W;

  // radicand 2^(2F) - x*x and the sqrt root fit in these widths
  localparam int SQ_W   = 2 * FRAC_BITS + 1;
  localparam int ROOT_W = FRAC_BITS + 1;

  localparam logic signed [X_W-1:0]   ONE_X   = X_W'(64'sd1 << FRAC_BITS);
  localparam logic signed [X_W-1:0]   M_ONE_X = -ONE_X;
  localparam logic signed [VAL_W-1:0] ONE_Q   = VAL_W'(64'sd1 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

`default_nettype wire

/* design/ale_mul.sv */
// iterative 64x64 unsigned multiplier, one 32x32 partial product per cycle
// depends on ale_pkg
`default_nettype none

module ale_mul
  import ale_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [VAL_W-1:0]  a_i,
  input  wire logic [VAL_W-1:0]  b_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      prod_o
);

  localparam int HW = VAL_W / 2;

  logic              busy_q;
  logic              done_q;
  logic [1:0]        cnt_q;
  logic [VAL_W-1:0]  a_q;
  logic [VAL_W-1:0]  b_q;
  logic [PROD_W-1:0] acc_q;

  logic [HW-1:0]     a_half;
  logic [HW-1:0]     b_half;
  logic [VAL_W-1:0]  pp;
  logic [PROD_W-1:0] pp_shifted;

  // cnt[1] picks the half of a, cnt[0] the half of b
  assign a_half     = cnt_q[1] ? a_q[VAL_W-1:HW] : a_q[HW-1:0];
  assign b_half     = cnt_q[0] ? b_q[VAL_W-1:HW] : b_q[HW-1:0];
  assign pp         = VAL_W'(a_half) * VAL_W'(b_half);
  assign pp_shifted = PROD_W'(pp) << ({cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0]} * HW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_shifted;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

/* design/ale_div.sv */
// radix-4 divider of a 64-bit magnitude by a small 3-bit divisor
// depends on ale_pkg
`default_nettype none

module ale_div
  import ale_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [VAL_W-1:0]  num_i,
  input  wire logic [2:0]        den_i,
  output logic                   done_o,
  output logic [VAL_W-1:0]       quo_o
);

  localparam int STEPS = VAL_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [VAL_W-1:0] n_q;
  logic [2:0]       d_q;
  logic [2:0]       rem_q;

  logic [4:0] part;
  logic [4:0] d1;
  logic [4:0] d2;
  logic [4:0] d3;
  logic [1:0] digit;
  logic [4:0] part_rem;

  assign part = {rem_q, n_q[VAL_W-1 -: 2]};
  assign d1   = {2'b00, d_q};
  assign d2   = {1'b0, d_q, 1'b0};
  assign d3   = d1 + d2;

  always_comb begin
    if (part >= d3) begin
      digit    = 2'd3;
      part_rem = part - d3;
    end else if (part >= d2) begin
      digit    = 2'd2;
      part_rem = part - d2;
    end else if (part >= d1) begin
      digit    = 2'd1;
      part_rem = part - d1;
    end else begin
      digit    = 2'd0;
      part_rem = part;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient digits shift in where dividend digits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[VAL_W-3:0], digit};
      rem_q <= part_rem[2:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

`default_nettype wire

/* design/associated_legendre_eval.sv */
// associated legendre polynomial P(l,m,x) in fixed point, upward recurrence in l
// depends on ale_pkg, ale_mul, ale_div
// sequence: m > l goes straight to a registered zero result; a recurrence step runs
//   two multiplies, a radix-4 divide and two sequencing states (S_RA_START, S_SUB);
//   m > 0 adds a multiply for x*x, the bitwise sqrt and a multiply per order
// throughput: one item at a time, in_stall_o is high until the result is registered
// reset: asynchronous, active low, block returns idle with no result pending
`default_nettype none

module associated_legendre_eval
  import ale_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [BAND_W-1:0]       band_i,
  input  wire logic [BAND_W-1:0]       order_i,
  input  wire logic signed [X_W-1:0]   arg_x_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [VAL_W-1:0]      poly_value_o,
  output logic                         saturated_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_WAIT,
    S_SQRT,
    S_MM_START,
    S_MM_WAIT,
    S_MM_DONE,
    S_M1_WAIT,
    S_RA_START,
    S_RA_WAIT,
    S_RB_WAIT,
    S_SUB,
    S_DIV_WAIT,
    S_FINISH
  } state_e;

  // ---------------------------------------------------------------- helpers

  function automatic logic [VAL_W-1:0] mag64(input logic signed [VAL_W-1:0] a);
    return a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
  endfunction

  // small non-negative integer times a 32-bit value, exact
  function automatic logic signed [VAL_W-1:0] kmul(input logic signed [X_W-1:0] v,
                                                   input logic [3:0] k);
    logic signed [X_W+4:0] p;
    p = $signed((X_W+5)'(v)) * $signed({(X_W+1)'(0), k});
    return VAL_W'(p);
  endfunction

  // {flag, value}: magnitude with sign back into the signed range
  function automatic logic [VAL_W:0] sat_mag(input logic [PROD_W-1:0] mag, input logic neg);
    logic [PROD_W-1:0] lim;
    lim = PROD_W'(1) << (VAL_W - 1);
    if (neg) begin
      if (mag >= lim) return {mag != lim, VAL_MIN};
      return {1'b0, VAL_W'(-mag[VAL_W-1:0])};
    end
    if (mag[PROD_W-1:VAL_W-1] != '0) return {1'b1, VAL_MAX};
    return {1'b0, mag[VAL_W-1:0]};
  endfunction

  // fixed-point product rounding, ties away from zero
  function automatic logic [VAL_W:0] round_q(input logic [PROD_W-1:0] prod, input logic neg);
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] r;
    p = prod + (PROD_W'(1) << (FRAC_BITS - 1));
    r = p >> FRAC_BITS;
    if (r[PROD_W-1:VAL_W] != '0) return {1'b1, neg ? VAL_MIN : VAL_MAX};
    return sat_mag(r, neg);
  endfunction

  function automatic logic [VAL_W:0] sub_sat(input logic signed [VAL_W-1:0] a,
                                             input logic signed [VAL_W-1:0] b);
    logic [VAL_W:0] diff;
    diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (diff[VAL_W] != diff[VAL_W-1]) return {1'b1, diff[VAL_W] ? VAL_MIN : VAL_MAX};
    return {1'b0, diff[VAL_W-1:0]};
  endfunction

  // ---------------------------------------------------------------- registers

  state_e                    state_q;
  logic [BAND_W-1:0]         l_q;
  logic [BAND_W-1:0]         m_q;
  logic [BAND_W-1:0]         i_q;
  logic signed [X_W-1:0]     x_q;
  logic [ROOT_W-1:0]         s_q;
  logic signed [VAL_W-1:0]   pmm_q;
  logic signed [VAL_W-1:0]   pm1_q;
  logic signed [VAL_W-1:0]   ta_q;
  logic signed [VAL_W-1:0]   tb_q;
  logic signed [VAL_W-1:0]   res_q;
  logic                      flag_q;
  logic                      neg_q;

  logic                      mul_start_q;
  logic [VAL_W-1:0]          mul_a_q;
  logic [VAL_W-1:0]          mul_b_q;
  logic                      div_start_q;
  logic [VAL_W-1:0]          div_n_q;
  logic [2:0]                div_d_q;
  logic                      div_neg_q;

  logic [SQ_W-1:0]           sq_v_q;
  logic [SQ_W-1:0]           sq_res_q;
  logic [SQ_W-1:0]           sq_bit_q;

  logic                      out_valid_q;
  logic signed [VAL_W-1:0]   poly_q;
  logic                      sat_q;

  // ---------------------------------------------------------------- units

  logic                      mul_done;
  logic [PROD_W-1:0]         mul_prod;
  logic                      div_done;
  logic [VAL_W-1:0]          div_quo;

  ale_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ale_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_n_q),
    .den_i   (div_d_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------- datapath

  logic signed [X_W-1:0]     x_clamp;
  logic [SQ_W:0]             sq_sum;
  logic                      sq_ge;
  logic [SQ_W-1:0]           sq_v_nx;
  logic [SQ_W-1:0]           sq_res_nx;
  logic [VAL_W:0]            rnd;
  logic [VAL_W:0]            exact;
  logic [VAL_W:0]            diff;
  logic [3:0]                k_odd;
  logic [3:0]                k_lm;
  logic signed [VAL_W-1:0]   mm_fac;
  logic signed [VAL_W-1:0]   m1_fac;
  logic signed [VAL_W-1:0]   ra_fac;
  logic signed [VAL_W-1:0]   div_q;

  always_comb begin
    if (arg_x_i > ONE_X) begin
      x_clamp = ONE_X;
    end else if (arg_x_i < M_ONE_X) begin
      x_clamp = M_ONE_X;
    end else begin
      x_clamp = arg_x_i;
    end
  end

  // one step of the bitwise integer sqrt
  assign sq_sum    = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
  assign sq_ge     = {1'b0, sq_v_q} >= sq_sum;
  assign sq_v_nx   = sq_ge ? sq_v_q - sq_sum[SQ_W-1:0] : sq_v_q;
  assign sq_res_nx = sq_ge ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;

  assign rnd   = round_q(mul_prod, neg_q);
  assign exact = sat_mag(mul_prod, neg_q);
  assign diff  = sub_sat(ta_q, tb_q);

  assign k_odd  = {i_q, 1'b0} - 4'd1;
  assign k_lm   = 4'(i_q) + 4'(m_q) - 4'd1;
  assign mm_fac = -kmul($signed(X_W'(s_q)), k_odd);
  assign m1_fac = kmul(x_q, {m_q, 1'b1});
  assign ra_fac = kmul(x_q, k_odd);
  assign div_q  = div_neg_q ? $signed(-div_quo) : $signed(div_quo);

  // ---------------------------------------------------------------- sequencer

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      l_q         <= '0;
      m_q         <= '0;
      i_q         <= '0;
      x_q         <= '0;
      s_q         <= '0;
      pmm_q       <= '0;
      pm1_q       <= '0;
      ta_q        <= '0;
      tb_q        <= '0;
      res_q       <= '0;
      flag_q      <= 1'b0;
      neg_q       <= 1'b0;
      mul_start_q <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_start_q <= 1'b0;
      div_n_q     <= '0;
      div_d_q     <= '0;
      div_neg_q   <= 1'b0;
      sq_v_q      <= '0;
      sq_res_q    <= '0;
      sq_bit_q    <= '0;
      out_valid_q <= 1'b0;
      poly_q      <= '0;
      sat_q       <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      // the finish state reloads the output beat itself
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            l_q    <= band_i;
            m_q    <= order_i;
            x_q    <= x_clamp;
            i_q    <= BAND_W'(1);
            pmm_q  <= ONE_Q;
            flag_q <= 1'b0;
            if ((32'(band_i) > MAX_BAND) || (order_i > band_i)) begin
              res_q   <= '0;
              state_q <= S_FINISH;
            end else if (order_i != '0) begin
              mul_a_q     <= mag64(VAL_W'(x_clamp));
              mul_b_q     <= mag64(VAL_W'(x_clamp));
              neg_q       <= 1'b0;
              mul_start_q <= 1'b1;
              state_q     <= S_SQ_WAIT;
            end else begin
              state_q <= S_MM_DONE;
            end
          end
        end

        S_SQ_WAIT: begin
          if (mul_done) begin
            sq_v_q   <= (SQ_W'(1) << (2 * FRAC_BITS)) - mul_prod[SQ_W-1:0];
            sq_res_q <= '0;
            sq_bit_q <= SQ_W'(1) << (2 * FRAC_BITS);
            state_q  <= S_SQRT;
          end
        end

        S_SQRT: begin
          sq_v_q   <= sq_v_nx;
          sq_res_q <= sq_res_nx;
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            s_q     <= sq_res_nx[ROOT_W-1:0];
            state_q <= S_MM_START;
          end
        end

        // pmm *= -(2i-1)*s for i = 1..m
        S_MM_START: begin
          mul_a_q     <= mag64(pmm_q);
          mul_b_q     <= mag64(mm_fac);
          neg_q       <= pmm_q[VAL_W-1] ^ mm_fac[VAL_W-1];
          mul_start_q <= 1'b1;
          state_q     <= S_MM_WAIT;
        end

        S_MM_WAIT: begin
          if (mul_done) begin
            pmm_q  <= rnd[VAL_W-1:0];
            flag_q <= flag_q | rnd[VAL_W];
            if (i_q == m_q) begin
              state_q <= S_MM_DONE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_MM_START;
            end
          end
        end

        S_MM_DONE: begin
          if (l_q == m_q) begin
            res_q   <= pmm_q;
            state_q <= S_FINISH;
          end else begin
            mul_a_q     <= mag64(m1_fac);
            mul_b_q     <= mag64(pmm_q);
            neg_q       <= m1_fac[VAL_W-1] ^ pmm_q[VAL_W-1];
            mul_start_q <= 1'b1;
            state_q     <= S_M1_WAIT;
          end
        end

        S_M1_WAIT: begin
          if (mul_done) begin
            pm1_q  <= rnd[VAL_W-1:0];
            flag_q <= flag_q | rnd[VAL_W];
            if (l_q == m_q + 1'b1) begin
              res_q   <= rnd[VAL_W-1:0];
              state_q <= S_FINISH;
            end else begin
              i_q     <= m_q + BAND_W'(2);
              state_q <= S_RA_START;
            end
          end
        end

        // recurrence: ((2i-1)*x*pm1 - (i+m-1)*pmm) / (i-m)
        S_RA_START: begin
          mul_a_q     <= mag64(ra_fac);
          mul_b_q     <= mag64(pm1_q);
          neg_q       <= ra_fac[VAL_W-1] ^ pm1_q[VAL_W-1];
          mul_start_q <= 1'b1;
          state_q     <= S_RA_WAIT;
        end

        S_RA_WAIT: begin
          if (mul_done) begin
            ta_q        <= rnd[VAL_W-1:0];
            flag_q      <= flag_q | rnd[VAL_W];
            mul_a_q     <= mag64(pmm_q);
            mul_b_q     <= VAL_W'(k_lm);
            neg_q       <= pmm_q[VAL_W-1];
            mul_start_q <= 1'b1;
            state_q     <= S_RB_WAIT;
          end
        end

        S_RB_WAIT: begin
          if (mul_done) begin
            tb_q    <= exact[VAL_W-1:0];
            flag_q  <= flag_q | exact[VAL_W];
            state_q <= S_SUB;
          end
        end

        S_SUB: begin
          flag_q      <= flag_q | diff[VAL_W];
          div_n_q     <= mag64(diff[VAL_W-1:0]);
          div_neg_q   <= diff[VAL_W-1];
          div_d_q     <= i_q - m_q;
          div_start_q <= 1'b1;
          state_q     <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            pmm_q <= pm1_q;
            pm1_q <= div_q;
            if (i_q == l_q) begin
              res_q   <= div_q;
              state_q <= S_FINISH;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RA_START;
            end
          end
        end

        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            poly_q      <= res_q;
            sat_q       <= flag_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign poly_value_o = poly_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire
